### rtl/spa_pkg.sv
`default_nettype none

package spa_pkg;

    localparam int SIZE_W   = 16;
    localparam int SLOT_W   = 6;
    localparam int STATUS_W = 2;
    localparam int FREE_W   = 7;

    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd3;

    localparam logic [SIZE_W-1:0] MAX_SIZE_RESET = 16'd256;

    typedef struct packed {
        logic [SLOT_W-1:0]   last_active;
        logic [SLOT_W-1:0]   first_active;
        logic                active_empty;
        logic [FREE_W-1:0]   free_slots;
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   granted_slot;
    } result_t;

endpackage

`default_nettype wire

### rtl/slot_pool_allocator.sv
`default_nettype none

// Slot pool allocator: hands out and takes back slots of a fixed pool, keeping
// a last-in-first-out free list and an oldest-first active list in two link
// memories (forward and backward), one entry per slot plus two list heads.
// Each request returns one response with the granted slot, a status, the free
// count and the oldest and newest active slots. After reset the block runs a
// clearing pass over all POOL_SLOTS slot entries that rebuilds the free chain,
// and takes no request meanwhile; max_object_size may be written at any time
// while the block is idle. A refused request goes straight to the response;
// a granted or released one first rewrites its links, and a second forward
// link rewrite needs a state of its own, set by the single forward write port.
// Responses wait in an output register so the next request can be taken.

module slot_pool_allocator
    import spa_pkg::*;
#(
    parameter int POOL_SLOTS = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // object_size[15:0], slot[21:16]
    input  wire logic        s_tuser,   // mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // granted_slot[5:0], free_slots[12:6],
                                        // active_empty[13], first_active[19:14],
                                        // last_active[25:20]
    output logic      [1:0]  m_tuser    // status
);

    localparam int ENTRIES = POOL_SLOTS + 2;
    localparam int EW      = $clog2(ENTRIES);

    logic          fwd_we;
    logic [EW-1:0] fwd_waddr;
    logic [EW-1:0] fwd_wdata;
    logic [EW-1:0] fwd_raddr;
    logic [EW-1:0] fwd_rdata;
    logic          bwd_we;
    logic [EW-1:0] bwd_waddr;
    logic [EW-1:0] bwd_wdata;
    logic [EW-1:0] bwd_raddr;
    logic [EW-1:0] bwd_rdata;
    logic          res_valid;
    logic          res_ready;
    result_t       res;

    spa_ram #(
        .WIDTH (EW),
        .DEPTH (ENTRIES)
    ) u_fwd_ram (
        .clk   (clk),
        .we    (fwd_we),
        .waddr (fwd_waddr),
        .wdata (fwd_wdata),
        .raddr (fwd_raddr),
        .rdata (fwd_rdata)
    );

    spa_ram #(
        .WIDTH (EW),
        .DEPTH (ENTRIES)
    ) u_bwd_ram (
        .clk   (clk),
        .we    (bwd_we),
        .waddr (bwd_waddr),
        .wdata (bwd_wdata),
        .raddr (bwd_raddr),
        .rdata (bwd_rdata)
    );

    spa_ctrl #(
        .POOL_SLOTS (POOL_SLOTS),
        .EW         (EW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_mode   (s_tuser),
        .in_size   (s_tdata[15:0]),
        .in_slot   (s_tdata[21:16]),
        .fwd_we    (fwd_we),
        .fwd_waddr (fwd_waddr),
        .fwd_wdata (fwd_wdata),
        .fwd_raddr (fwd_raddr),
        .fwd_rdata (fwd_rdata),
        .bwd_we    (bwd_we),
        .bwd_waddr (bwd_waddr),
        .bwd_wdata (bwd_wdata),
        .bwd_raddr (bwd_raddr),
        .bwd_rdata (bwd_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    spa_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

### rtl/spa_ram.sv
`default_nettype none

module spa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### rtl/spa_ctrl.sv
`default_nettype none

module spa_ctrl
    import spa_pkg::*;
#(
    parameter int POOL_SLOTS = 64,
    parameter int EW         = $clog2(POOL_SLOTS + 2)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [SIZE_W-1:0] cfg_wdata,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              in_mode,
    input  wire logic [SIZE_W-1:0] in_size,
    input  wire logic [SLOT_W-1:0] in_slot,
    output logic                   fwd_we,
    output logic      [EW-1:0]     fwd_waddr,
    output logic      [EW-1:0]     fwd_wdata,
    output logic      [EW-1:0]     fwd_raddr,
    input  wire logic [EW-1:0]     fwd_rdata,
    output logic                   bwd_we,
    output logic      [EW-1:0]     bwd_waddr,
    output logic      [EW-1:0]     bwd_wdata,
    output logic      [EW-1:0]     bwd_raddr,
    input  wire logic [EW-1:0]     bwd_rdata,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output result_t                res
);

    localparam int ENTRIES = POOL_SLOTS + 2;
    localparam int CW      = $clog2(POOL_SLOTS + 1);
    localparam int XW      = ((EW > SLOT_W) ? EW : SLOT_W) + 1;
    localparam int FXW     = CW + FREE_W;

    localparam logic [EW-1:0] ACT_HEAD   = '0;
    localparam logic [EW-1:0] FREE_HEAD  = EW'(1);
    localparam logic [EW-1:0] FIRST_SLOT = EW'(2);
    localparam logic [EW-1:0] LAST_ENTRY = EW'(ENTRIES - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(POOL_SLOTS);

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_A_WB = 3'd2;
    localparam logic [2:0] S_R_WB = 3'd3;
    localparam logic [2:0] S_WB2  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    function automatic logic [SLOT_W-1:0] slot_of(input logic [EW-1:0] x);
        logic [XW-1:0] t;
        t = XW'(x) - XW'(2);
        return t[SLOT_W-1:0];
    endfunction

    function automatic logic is_sentinel(input logic [EW-1:0] x);
        return (x == ACT_HEAD) || (x == FREE_HEAD);
    endfunction

    logic [2:0]        state_reg, state_next;
    logic [EW-1:0]     init_cnt_reg, init_cnt_next;
    logic [CW-1:0]     free_count_reg, free_count_next;
    logic [SIZE_W-1:0] max_size_reg;
    logic [EW-1:0]     fwd0_reg, fwd0_next;
    logic [EW-1:0]     fwd1_reg, fwd1_next;
    logic [EW-1:0]     bwd0_reg, bwd0_next;
    logic [EW-1:0]     bwd1_reg, bwd1_next;

    logic [EW-1:0]       e_reg, e_next;
    logic [EW-1:0]       tail_reg, tail_next;
    logic [EW-1:0]       wb2_addr_reg, wb2_addr_next;
    logic [EW-1:0]       wb2_data_reg, wb2_data_next;
    logic [SLOT_W-1:0]   granted_reg, granted_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic [XW-1:0]  slot_x;
    logic [EW-1:0]  e_in;
    logic           slot_ok;
    logic [EW-1:0]  alloc_d;
    logic [EW-1:0]  rel_p;
    logic [EW-1:0]  rel_n;
    logic [EW-1:0]  rel_x;
    logic [FXW-1:0] free_x;

    assign slot_x  = XW'(in_slot);
    assign slot_ok = slot_x < XW'(POOL_SLOTS);
    assign e_in    = EW'(slot_x + XW'(2));

    assign fwd_raddr = (in_mode == MODE_RELEASE) ? e_in : fwd1_reg;
    assign bwd_raddr = e_in;

    assign alloc_d = (e_reg == ACT_HEAD)  ? fwd0_reg :
                     (e_reg == FREE_HEAD) ? fwd1_reg : fwd_rdata;
    assign rel_p   = bwd_rdata;
    assign rel_n   = fwd_rdata;
    assign rel_x   = (rel_p == FREE_HEAD) ? rel_n : fwd1_reg;

    assign free_x = FXW'(free_count_reg);

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_OUT);

    always_comb
    begin
        res.granted_slot = granted_reg;
        res.status       = status_reg;
        res.free_slots   = free_x[FREE_W-1:0];
        res.active_empty = (fwd0_reg == ACT_HEAD);
        res.first_active = (fwd0_reg == ACT_HEAD) ? '0 : slot_of(fwd0_reg);
        res.last_active  = (fwd0_reg == ACT_HEAD) ? '0 : slot_of(bwd0_reg);
    end

    always_comb
    begin
        state_next      = state_reg;
        init_cnt_next   = init_cnt_reg;
        free_count_next = free_count_reg;
        fwd0_next       = fwd0_reg;
        fwd1_next       = fwd1_reg;
        bwd0_next       = bwd0_reg;
        bwd1_next       = bwd1_reg;
        e_next          = e_reg;
        tail_next       = tail_reg;
        wb2_addr_next   = wb2_addr_reg;
        wb2_data_next   = wb2_data_reg;
        granted_next    = granted_reg;
        status_next     = status_reg;
        fwd_we          = 1'b0;
        fwd_waddr       = e_reg;
        fwd_wdata       = '0;
        bwd_we          = 1'b0;
        bwd_waddr       = e_reg;
        bwd_wdata       = '0;

        unique case (state_reg)
            S_INIT:
            begin
                fwd_we    = 1'b1;
                fwd_waddr = init_cnt_reg;
                fwd_wdata = (init_cnt_reg == LAST_ENTRY) ? FREE_HEAD
                                                         : init_cnt_reg + EW'(1);
                bwd_we    = 1'b1;
                bwd_waddr = init_cnt_reg;
                bwd_wdata = ACT_HEAD;
                if (init_cnt_reg == LAST_ENTRY)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    init_cnt_next = init_cnt_reg + EW'(1);
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    granted_next = '0;
                    status_next  = ST_OK;
                    if (in_mode == MODE_ALLOC)
                    begin
                        if (in_size > max_size_reg)
                        begin
                            status_next = ST_TOO_LARGE;
                            state_next  = S_OUT;
                        end
                        else if (free_count_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                            state_next  = S_OUT;
                        end
                        else
                        begin
                            e_next     = fwd1_reg;
                            tail_next  = bwd0_reg;
                            state_next = S_A_WB;
                        end
                    end
                    else
                    begin
                        if ((free_count_reg == FULL_COUNT) || !slot_ok)
                        begin
                            status_next = ST_OVERFLOW;
                            state_next  = S_OUT;
                        end
                        else
                        begin
                            e_next     = e_in;
                            state_next = S_R_WB;
                        end
                    end
                end
            end
            S_A_WB:
            begin
                // pop free head, link it after the active tail
                fwd_we    = !is_sentinel(e_reg);
                fwd_waddr = e_reg;
                fwd_wdata = (tail_reg == e_reg) ? e_reg : ACT_HEAD;
                bwd_we    = !is_sentinel(e_reg);
                bwd_waddr = e_reg;
                bwd_wdata = tail_reg;
                fwd1_next = (tail_reg == FREE_HEAD) ? e_reg :
                            (e_reg == FREE_HEAD)    ? ACT_HEAD : alloc_d;
                fwd0_next = (tail_reg == ACT_HEAD)  ? e_reg :
                            (e_reg == ACT_HEAD)     ? ACT_HEAD : fwd0_reg;
                bwd0_next = e_reg;
                bwd1_next = (e_reg == FREE_HEAD) ? tail_reg : bwd1_reg;
                free_count_next = free_count_reg - CW'(1);
                granted_next    = slot_of(e_reg);
                wb2_addr_next   = tail_reg;
                wb2_data_next   = e_reg;
                if (!is_sentinel(tail_reg) && (tail_reg != e_reg))
                begin
                    state_next = S_WB2;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_R_WB:
            begin
                // unlink from active list, push onto free list
                fwd_we    = 1'b1;
                fwd_waddr = e_reg;
                fwd_wdata = rel_x;
                bwd_we    = !is_sentinel(rel_n);
                bwd_waddr = rel_n;
                bwd_wdata = rel_p;
                fwd0_next = (rel_p == ACT_HEAD)  ? rel_n : fwd0_reg;
                fwd1_next = e_reg;
                bwd0_next = (rel_n == ACT_HEAD)  ? rel_p : bwd0_reg;
                bwd1_next = (rel_n == FREE_HEAD) ? rel_p : bwd1_reg;
                free_count_next = free_count_reg + CW'(1);
                wb2_addr_next   = rel_p;
                wb2_data_next   = rel_n;
                if (!is_sentinel(rel_p) && (rel_p != e_reg))
                begin
                    state_next = S_WB2;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_WB2:
            begin
                fwd_we     = 1'b1;
                fwd_waddr  = wb2_addr_reg;
                fwd_wdata  = wb2_data_reg;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            init_cnt_reg   <= FIRST_SLOT;
            free_count_reg <= FULL_COUNT;
            max_size_reg   <= MAX_SIZE_RESET;
            fwd0_reg       <= ACT_HEAD;
            fwd1_reg       <= FIRST_SLOT;
            bwd0_reg       <= ACT_HEAD;
            bwd1_reg       <= ACT_HEAD;
        end
        else
        begin
            state_reg      <= state_next;
            init_cnt_reg   <= init_cnt_next;
            free_count_reg <= free_count_next;
            fwd0_reg       <= fwd0_next;
            fwd1_reg       <= fwd1_next;
            bwd0_reg       <= bwd0_next;
            bwd1_reg       <= bwd1_next;
            if (cfg_we)
            begin
                max_size_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg        <= e_next;
        tail_reg     <= tail_next;
        wb2_addr_reg <= wb2_addr_next;
        wb2_data_reg <= wb2_data_next;
        granted_reg  <= granted_next;
        status_reg   <= status_next;
    end

endmodule

`default_nettype wire

### rtl/spa_out_stage.sv
`default_nettype none

module spa_out_stage
    import spa_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    res_valid,
    output logic         res_ready,
    input  wire result_t res,
    output logic         m_tvalid,
    input  wire logic    m_tready,
    output logic [31:0]  m_tdata,
    output logic [1:0]   m_tuser
);

    logic    valid_reg;
    result_t res_reg;

    assign res_ready = !valid_reg || m_tready;
    assign m_tvalid  = valid_reg;
    assign m_tuser   = res_reg.status;
    assign m_tdata   = {6'b0, res_reg.last_active, res_reg.first_active,
                        res_reg.active_empty, res_reg.free_slots, res_reg.granted_slot};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            res_reg <= res;
        end
    end

endmodule

`default_nettype wire
